// ===== rtl/erc_pkg.sv =====
// Package: shared types and constants of the 8-bit RISC instruction core
package erc_pkg;

  localparam int unsigned XLEN        = 8;
  localparam int unsigned ADDR_SPAN   = 1 << XLEN;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned INSTR_W     = 16;
  localparam int unsigned FIELD_W     = 4;
  localparam int unsigned REG_COUNT   = 16;
  localparam int unsigned REG_AW      = $clog2(REG_COUNT);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_EXEC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MEM_WR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MEM_RD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REG_WR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REG_RD = 3'd4;

  typedef enum logic [2:0] {
    KIND_EXEC   = 3'd0,
    KIND_MEM_WR = 3'd1,
    KIND_MEM_RD = 3'd2,
    KIND_REG_WR = 3'd3,
    KIND_REG_RD = 3'd4,
    KIND_NONE   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_INC  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SLLI = 4'd8,
    OP_SRLI = 4'd9,
    OP_LI   = 4'd10,
    OP_LD   = 4'd11,
    OP_ST   = 4'd12,
    OP_JMP  = 4'd13,
    OP_BEQZ = 4'd14,
    OP_HALT = 4'd15
  } opcode_e;

  typedef struct packed {
    kind_e               kind;
    opcode_e             op;
    logic [FIELD_W-1:0]  fa;
    logic [FIELD_W-1:0]  fb;
    logic [FIELD_W-1:0]  fc;
    logic [REG_AW-1:0]   ra0;
    logic [REG_AW-1:0]   ra1;
    logic [XLEN-1:0]     addr;
    logic [XLEN-1:0]     value;
  } cmd_t;

endpackage

// ===== rtl/erc_intf.sv =====
// Interfaces: input and result channels of the instruction core
interface erc_in_if import erc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [INSTR_W-1:0]       instr;
  logic [XLEN-1:0]          addr;
  logic signed [XLEN-1:0]   value;

  modport source (output valid, mode, instr, addr, value, input ready);
  modport sink   (input valid, mode, instr, addr, value, output ready);
endinterface

interface erc_out_if import erc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [XLEN-1:0]          next_pc;
  logic                     halted;
  logic signed [XLEN-1:0]   read_value;
  logic                     mem_written;

  modport source (output valid, next_pc, halted, read_value, mem_written, input ready);
  modport sink   (input valid, next_pc, halted, read_value, mem_written, output ready);
endinterface

// ===== rtl/erc_ram.sv =====
// Generic RAM: one write port, one read port with registered read data
module erc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/erc_front.sv =====
// Front end: accept items and classify them into execution commands
module erc_front import erc_pkg::*; (
  erc_in_if.sink  in_i,
  input  logic    full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  opcode_e            op;
  kind_e              kind;
  logic [FIELD_W-1:0] fa;
  logic [FIELD_W-1:0] fb;
  logic [FIELD_W-1:0] fc;

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  always_comb begin
    op = opcode_e'(in_i.instr[15:12]);
    fa = in_i.instr[11:8];
    fb = in_i.instr[7:4];
    fc = in_i.instr[3:0];

    unique case (in_i.mode)
      MODE_EXEC:   kind = KIND_EXEC;
      MODE_MEM_WR: kind = KIND_MEM_WR;
      MODE_MEM_RD: kind = KIND_MEM_RD;
      MODE_REG_WR: kind = KIND_REG_WR;
      MODE_REG_RD: kind = KIND_REG_RD;
      default:     kind = KIND_NONE;
    endcase

    cmd_o       = '0;
    cmd_o.kind  = kind;
    cmd_o.op    = op;
    cmd_o.fa    = fa;
    cmd_o.fb    = fb;
    cmd_o.fc    = fc;
    cmd_o.addr  = in_i.addr;
    cmd_o.value = $unsigned(in_i.value);

    if (kind == KIND_REG_RD) begin
      cmd_o.ra0 = in_i.addr[REG_AW-1:0];
    end else begin
      unique case (op) inside
        OP_INC, OP_BEQZ: cmd_o.ra0 = fa;
        default:         cmd_o.ra0 = fb;
      endcase
    end

    cmd_o.ra1 = (op == OP_ST) ? fa : fc;
  end

endmodule

// ===== rtl/erc_queue.sv =====
// Command queue between front end and execution back end
module erc_queue import erc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

// ===== rtl/erc_back.sv =====
// Back end: operand read, execute with data memory access, writeback and result
module erc_back import erc_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  erc_out_if.source   out_o
);

  localparam int unsigned DAW = $clog2(DATA_DEPTH);

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic              rf_we;
    logic [REG_AW-1:0] rf_addr;
    logic [XLEN-1:0]   rf_data;
    logic              ld;
    logic              rd_mem;
    logic [XLEN-1:0]   rv;
    logic [XLEN-1:0]   next_pc;
    logic              halted;
    logic              mem_written;
  } res_t;

  logic              en;
  logic [XLEN-1:0]   rf_rd0, rf_rd1;
  logic [REG_COUNT-1:0] rf_vld_q;
  logic              rv0_q, rv1_q;
  rf_wr_t            rf_wr, s3_wr, wb_q;

  logic              s2_v_q;
  cmd_t              s2_q;
  logic              s3_v_q;
  res_t              s3_q, s3_d;
  logic              s3_dvld_q;

  logic [XLEN-1:0]   pc_q, pc_d;
  logic              halted_q, halted_d;

  logic [XLEN-1:0]   opnd0, opnd1;
  logic [XLEN-1:0]   pc2, eff, alu;
  logic [XLEN-1:0]   prod;
  logic              live;

  logic [DAW-1:0]    idx_tbl [ADDR_SPAN];
  logic [XLEN-1:0]   dm_addr8;
  logic [DAW-1:0]    dm_idx;
  logic              dm_we_c, dm_we;
  logic [XLEN-1:0]   dm_wdata, dm_rdata, dm_data;
  logic [DATA_DEPTH-1:0] dm_vld_q;

  assign en    = ~s3_v_q | out_o.ready;
  assign pop_o = en & ~empty_i;

  erc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf0 (
    .clk_i   (clk_i),
    .we_i    (rf_wr.we),
    .waddr_i (rf_wr.addr),
    .wdata_i (rf_wr.data),
    .re_i    (en),
    .raddr_i (head_i.ra0),
    .rdata_o (rf_rd0)
  );

  erc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf1 (
    .clk_i   (clk_i),
    .we_i    (rf_wr.we),
    .waddr_i (rf_wr.addr),
    .wdata_i (rf_wr.data),
    .re_i    (en),
    .raddr_i (head_i.ra1),
    .rdata_o (rf_rd1)
  );

  erc_ram #(.WIDTH(XLEN), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_idx),
    .wdata_i (dm_wdata),
    .re_i    (en),
    .raddr_i (dm_idx),
    .rdata_o (dm_rdata)
  );

  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_idx
    assign idx_tbl[g] = DAW'(g % DATA_DEPTH);
  end

  // writeback from the result stage
  assign dm_data    = s3_dvld_q ? dm_rdata : '0;
  assign s3_wr.we   = s3_v_q & s3_q.rf_we;
  assign s3_wr.addr = s3_q.rf_addr;
  assign s3_wr.data = s3_q.ld ? dm_data : s3_q.rf_data;
  assign rf_wr.we   = en & s3_wr.we;
  assign rf_wr.addr = s3_wr.addr;
  assign rf_wr.data = s3_wr.data;

  // operand bypass: result stage first, then last retired write, then array
  always_comb begin
    opnd0 = rv0_q ? rf_rd0 : '0;
    opnd1 = rv1_q ? rf_rd1 : '0;
    if (wb_q.we && wb_q.addr == s2_q.ra0) begin
      opnd0 = wb_q.data;
    end
    if (wb_q.we && wb_q.addr == s2_q.ra1) begin
      opnd1 = wb_q.data;
    end
    if (s3_wr.we && s3_wr.addr == s2_q.ra0) begin
      opnd0 = s3_wr.data;
    end
    if (s3_wr.we && s3_wr.addr == s2_q.ra1) begin
      opnd1 = s3_wr.data;
    end
  end

  always_comb begin
    pc2      = pc_q + XLEN'(2);
    eff      = opnd0 + {{(XLEN - FIELD_W){s2_q.fc[FIELD_W-1]}}, s2_q.fc};
    prod     = opnd0 * opnd1;
    live     = s2_v_q & (s2_q.kind == KIND_EXEC) & ~halted_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    alu      = opnd0 + opnd1;

    unique case (s2_q.op)
      OP_ADD:  alu = opnd0 + opnd1;
      OP_SUB:  alu = opnd0 - opnd1;
      OP_MUL:  alu = prod;
      OP_INC:  alu = opnd0 + 1'b1;
      OP_AND:  alu = opnd0 & opnd1;
      OP_OR:   alu = opnd0 | opnd1;
      OP_XOR:  alu = opnd0 ^ opnd1;
      OP_NOT:  alu = ~opnd0;
      OP_SLLI: alu = s2_q.fc[FIELD_W-1] ? '0 : opnd0 << s2_q.fc[FIELD_W-2:0];
      OP_SRLI: alu = s2_q.fc[FIELD_W-1] ? '0 : opnd0 >> s2_q.fc[FIELD_W-2:0];
      OP_LI:   alu = {s2_q.fb, s2_q.fc};
      default: alu = opnd0 + opnd1;
    endcase

    s3_d         = '0;
    s3_d.rf_addr = s2_q.fa;
    s3_d.rf_data = alu;

    if (live) begin
      pc_d = pc2;
      unique case (s2_q.op)
        OP_LD: begin
          s3_d.rf_we = 1'b1;
          s3_d.ld    = 1'b1;
        end
        OP_ST: begin
          s3_d.rf_we = 1'b0;
        end
        OP_JMP: begin
          pc_d = pc2 + {s2_q.fa[FIELD_W-2:0], s2_q.fb, 1'b0};
        end
        OP_BEQZ: begin
          if (opnd0 == '0) begin
            pc_d = pc2 + {s2_q.fb[FIELD_W-2:0], s2_q.fc, 1'b0};
          end
        end
        OP_HALT: begin
          halted_d = 1'b1;
        end
        default: begin
          s3_d.rf_we = 1'b1;
        end
      endcase
    end

    if (s2_q.kind == KIND_REG_WR) begin
      s3_d.rf_we   = 1'b1;
      s3_d.rf_addr = s2_q.addr[REG_AW-1:0];
      s3_d.rf_data = s2_q.value;
    end
    s3_d.rd_mem = (s2_q.kind == KIND_MEM_RD);
    s3_d.rv     = (s2_q.kind == KIND_REG_RD) ? opnd0 : '0;

    dm_addr8 = (s2_q.kind == KIND_EXEC) ? eff : s2_q.addr;
    dm_idx   = idx_tbl[dm_addr8];
    dm_we_c  = s2_v_q & ((live & (s2_q.op == OP_ST)) | (s2_q.kind == KIND_MEM_WR));
    dm_wdata = (s2_q.kind == KIND_EXEC) ? opnd1 : s2_q.value;

    s3_d.mem_written = dm_we_c;
    s3_d.next_pc     = pc_d;
    s3_d.halted      = halted_d;
  end

  assign dm_we = en & dm_we_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      wb_q     <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      rf_vld_q <= '0;
      dm_vld_q <= '0;
    end else begin
      if (en) begin
        s2_v_q   <= pop_o;
        s3_v_q   <= s2_v_q;
        wb_q     <= s3_wr;
        pc_q     <= pc_d;
        halted_q <= halted_d;
      end
      if (rf_wr.we) begin
        rf_vld_q[rf_wr.addr] <= 1'b1;
      end
      if (dm_we) begin
        dm_vld_q[dm_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q      <= head_i;
      rv0_q     <= rf_vld_q[head_i.ra0];
      rv1_q     <= rf_vld_q[head_i.ra1];
      s3_q      <= s3_d;
      s3_dvld_q <= dm_vld_q[dm_idx];
    end
  end

  assign out_o.valid       = s3_v_q;
  assign out_o.next_pc     = s3_q.next_pc;
  assign out_o.halted      = s3_q.halted;
  assign out_o.read_value  = $signed(s3_q.rd_mem ? dm_data : s3_q.rv);
  assign out_o.mem_written = s3_q.mem_written;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");

  a_pc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> pc_q == $past(pc_q))
    else $error("program counter moved while halted");

  a_no_write_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (!dm_we && !rf_wr.we))
    else $error("state written while pipeline stalled");

endmodule

// ===== rtl/eight_bit_risc_instruction_core.sv =====
// Top level: 8-bit RISC instruction core with host access to registers and data memory
//
// Each item either executes one 16-bit instruction or reads/writes a data byte or a register,
// and returns one result item. Sustained rate is one item per clock while results are taken; an
// item passes the queue, the register file read and the execute and data memory access stage
// before its result leaves, as set by the registered read ports of the register file and
// the data memory. A two-entry command queue separates the decoder from the execution
// pipeline, and the queue takes further items while a result waits to be taken, until it is
// full. Register file and data memory read as zero after reset through per-entry valid
// bits, so no clearing pass is needed and items are taken right after reset.
module eight_bit_risc_instruction_core import erc_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  erc_in_if.sink      in_i,
  erc_out_if.source   out_o
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t cmd;
  cmd_t head;

  erc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  erc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  erc_back #(.DATA_DEPTH(DATA_DEPTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
